### sv/cgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgs_pkg
// shared types, codes and fixed-point helpers for the conjugate gradient solver
// ----------------------------------------------------------------------------
package cgs_pkg;

    localparam int MAX_DIM = 16;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int MAT_AW  = 2 * IDX_W;
    localparam int DIM_W   = 5;
    localparam int ITER_W  = 16;
    localparam int CFG_W   = 16;

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_LOAD_X = 2'd2;
    localparam logic [1:0] MODE_START  = 2'd3;

    localparam logic CFG_DIMENSION = 1'b0;
    localparam logic CFG_ITER_LIM  = 1'b1;

    typedef enum logic [3:0] {
        OP_RES = 4'd0,
        OP_Q   = 4'd1,
        OP_RR  = 4'd2,
        OP_PQ  = 4'd3,
        OP_X   = 4'd4,
        OP_R   = 4'd5,
        OP_RN  = 4'd6,
        OP_P   = 4'd7
    } op_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               zero;
        logic signed [31:0] quot;
    } div_rsp_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32_48(input logic signed [48:0] v);
        if (v[48:31] != {18{1'b0}} && v[48:31] != {18{1'b1}})
            return v[48] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] narrow(input logic signed [63:0] acc);
        logic signed [47:0] t;
        t = acc[63:16];
        if (t[47:31] != {17{1'b0}} && t[47:31] != {17{1'b1}})
            return t[47] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        return t[31:0];
    endfunction

    function automatic logic signed [63:0] widen(input logic signed [31:0] v);
        return {{16{v[31]}}, v, 16'd0};
    endfunction

endpackage

`default_nettype wire

### sv/cgs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgs channel interfaces
// input, output and configuration word channels with valid/ready
// ----------------------------------------------------------------------------
interface cgs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    modport source (output valid, mode, row, col, value, input ready);
    modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface cgs_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic               last;
    logic               status;
    modport source (output valid, index, solution, last, status, input ready);
    modport sink   (input valid, index, solution, last, status, output ready);
endinterface

interface cgs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic                        index;
    logic [cgs_pkg::CFG_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/cgs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgs_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module cgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/cgs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgs_div
// bit-serial signed q16.16 divider, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
module cgs_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cgs_pkg::div_req_t req,
    output cgs_pkg::div_rsp_t      rsp
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] dvd_reg;
    logic [31:0] dsr_reg;
    logic [31:0] rem_reg;
    logic        neg_reg;
    logic        done_reg;
    logic        zero_reg;
    logic signed [31:0] quot_reg;

    logic [32:0] rem_sh;
    logic        ge;
    logic [31:0] rem_next;
    logic [47:0] dvd_next;
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic signed [48:0] q_signed;

    always_comb
    begin
        num_mag  = req.num[31] ? 32'(-req.num) : 32'(req.num);
        den_mag  = req.den[31] ? 32'(-req.den) : 32'(req.den);
        rem_sh   = {rem_reg, dvd_reg[47]};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_next = ge ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
        dvd_next = {dvd_reg[46:0], ge};
        q_signed = neg_reg ? -$signed({1'b0, dvd_next}) : $signed({1'b0, dvd_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            neg_reg  <= 1'b0;
            zero_reg <= 1'b0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.den == 32'sd0)
                begin
                    done_reg <= 1'b1;
                    zero_reg <= 1'b1;
                    quot_reg <= '0;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    zero_reg <= 1'b0;
                    cnt_reg  <= 6'd47;
                    dvd_reg  <= {num_mag, 16'd0};
                    dsr_reg  <= den_mag;
                    rem_reg  <= '0;
                    neg_reg  <= req.num[31] ^ req.den[31];
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                dvd_reg <= dvd_next;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= cgs_pkg::sat32_48(q_signed);
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.zero = zero_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

### sv/cgs_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgs_core
// load path, iteration sequencer and multiply-accumulate over the stores
// ----------------------------------------------------------------------------
module cgs_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cgs_in_if.sink      in_ch,
    cgs_out_if.source   out_ch,
    cgs_cfg_if.sink     cfg_ch
);

    localparam int IW = cgs_pkg::IDX_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_ORD   = 7'b0100000,
        S_OWAIT = 7'b1000000
    } state_t;

    state_t        state_reg;
    cgs_pkg::op_t  op_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic [cgs_pkg::DIM_W-1:0]  n_reg;
    logic [cgs_pkg::DIM_W-1:0]  dim_reg;
    logic [cgs_pkg::ITER_W-1:0] limit_reg;
    logic [cgs_pkg::ITER_W-1:0] iter_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] init_reg;
    logic signed [31:0] rr_reg;
    logic signed [31:0] alpha_reg;
    logic signed [31:0] beta_reg;
    logic               fault_reg;

    logic [31:0] a_rd, b_rd, x_rd, r_rd, p_rd, q_rd;
    logic        a_we, b_we, x_we, r_we, p_we, q_we;
    logic [cgs_pkg::MAT_AW-1:0] a_wa;
    logic [IW-1:0] v_wa, x_ra, p_ra;
    logic [31:0]   x_wd, r_wd, p_wd;

    logic [IW-1:0] nm1;
    logic          is_mat, is_dot, first, inner_done, elem_last, load_go, acc_step;
    logic signed [31:0] opa, opb;
    logic signed [63:0] init_val, base, acc_new;
    logic signed [31:0] res32;
    logic [cgs_pkg::DIM_W-1:0] n_start;
    cgs_pkg::div_req_t div_req;
    cgs_pkg::div_rsp_t div_rsp;

    assign load_go  = (state_reg == S_IDLE) && in_ch.valid;
    assign acc_step = (state_reg == S_ACC);
    assign nm1      = IW'(n_reg - 5'd1);
    assign is_mat   = (op_reg == cgs_pkg::OP_RES) || (op_reg == cgs_pkg::OP_Q);
    assign is_dot   = (op_reg == cgs_pkg::OP_RR) || (op_reg == cgs_pkg::OP_PQ)
                   || (op_reg == cgs_pkg::OP_RN);
    assign first      = is_mat ? (j_reg == '0) : (is_dot ? (i_reg == '0) : 1'b1);
    assign inner_done = is_mat ? (j_reg == nm1) : 1'b1;
    assign elem_last  = (i_reg == nm1);

    assign x_ra = ((op_reg == cgs_pkg::OP_RES) && (state_reg != S_ORD)
                   && (state_reg != S_OWAIT)) ? j_reg : i_reg;
    assign p_ra = (op_reg == cgs_pkg::OP_Q) ? j_reg : i_reg;

    always_comb
    begin
        n_start = dim_reg;
        if (dim_reg == '0)
            n_start = 5'd1;
        else if (dim_reg > 5'(cgs_pkg::MAX_DIM))
            n_start = 5'(cgs_pkg::MAX_DIM);
    end

    always_comb
    begin
        opa      = $signed(r_rd);
        opb      = $signed(r_rd);
        init_val = '0;
        case (op_reg)
            cgs_pkg::OP_RES:
            begin
                opa      = $signed(a_rd);
                opb      = $signed(x_rd);
                init_val = cgs_pkg::widen($signed(b_rd));
            end
            cgs_pkg::OP_Q:
            begin
                opa = $signed(a_rd);
                opb = $signed(p_rd);
            end
            cgs_pkg::OP_PQ:
            begin
                opa = $signed(p_rd);
                opb = $signed(q_rd);
            end
            cgs_pkg::OP_X:
            begin
                opa      = alpha_reg;
                opb      = $signed(p_rd);
                init_val = cgs_pkg::widen($signed(x_rd));
            end
            cgs_pkg::OP_R:
            begin
                opa      = alpha_reg;
                opb      = $signed(q_rd);
                init_val = cgs_pkg::widen($signed(r_rd));
            end
            cgs_pkg::OP_P:
            begin
                opa      = beta_reg;
                opb      = $signed(p_rd);
                init_val = cgs_pkg::widen($signed(r_rd));
            end
            default:
            begin
                opa = $signed(r_rd);
                opb = $signed(r_rd);
            end
        endcase
    end

    always_comb
    begin
        base    = first ? init_reg : acc_reg;
        acc_new = ((op_reg == cgs_pkg::OP_RES) || (op_reg == cgs_pkg::OP_R))
                ? cgs_pkg::sat_sub64(base, prod_reg)
                : cgs_pkg::sat_add64(base, prod_reg);
        res32   = cgs_pkg::narrow(acc_new);
    end

    // store write ports
    always_comb
    begin
        a_we = load_go && (in_ch.mode == cgs_pkg::MODE_LOAD_A);
        a_wa = {in_ch.row, in_ch.col};
        b_we = load_go && (in_ch.mode == cgs_pkg::MODE_LOAD_B);
        v_wa = (state_reg == S_IDLE) ? in_ch.row : i_reg;
        x_we = (load_go && (in_ch.mode == cgs_pkg::MODE_LOAD_X))
            || (acc_step && (op_reg == cgs_pkg::OP_X));
        x_wd = (state_reg == S_IDLE) ? in_ch.value : res32;
        r_we = acc_step && inner_done
            && ((op_reg == cgs_pkg::OP_RES) || (op_reg == cgs_pkg::OP_R));
        r_wd = res32;
        p_we = acc_step && inner_done
            && ((op_reg == cgs_pkg::OP_RES) || (op_reg == cgs_pkg::OP_P));
        p_wd = res32;
        q_we = acc_step && inner_done && (op_reg == cgs_pkg::OP_Q);
    end

    always_comb
    begin
        div_req.start = acc_step && elem_last
                     && ((op_reg == cgs_pkg::OP_PQ) || (op_reg == cgs_pkg::OP_RN));
        div_req.num   = (op_reg == cgs_pkg::OP_PQ) ? rr_reg : res32;
        div_req.den   = (op_reg == cgs_pkg::OP_PQ) ? res32 : rr_reg;
    end

    cgs_ram #(.WIDTH(32), .DEPTH(cgs_pkg::MAX_DIM * cgs_pkg::MAX_DIM)) u_mat (
        .clk(clk), .we(a_we), .waddr(a_wa), .wdata(in_ch.value),
        .raddr({i_reg, j_reg}), .rdata(a_rd)
    );
    cgs_ram #(.WIDTH(32), .DEPTH(cgs_pkg::MAX_DIM)) u_rhs (
        .clk(clk), .we(b_we), .waddr(v_wa), .wdata(in_ch.value),
        .raddr(i_reg), .rdata(b_rd)
    );
    cgs_ram #(.WIDTH(32), .DEPTH(cgs_pkg::MAX_DIM)) u_sol (
        .clk(clk), .we(x_we), .waddr(v_wa), .wdata(x_wd),
        .raddr(x_ra), .rdata(x_rd)
    );
    cgs_ram #(.WIDTH(32), .DEPTH(cgs_pkg::MAX_DIM)) u_res (
        .clk(clk), .we(r_we), .waddr(v_wa), .wdata(r_wd),
        .raddr(i_reg), .rdata(r_rd)
    );
    cgs_ram #(.WIDTH(32), .DEPTH(cgs_pkg::MAX_DIM)) u_dir (
        .clk(clk), .we(p_we), .waddr(v_wa), .wdata(p_wd),
        .raddr(p_ra), .rdata(p_rd)
    );
    cgs_ram #(.WIDTH(32), .DEPTH(cgs_pkg::MAX_DIM)) u_prd (
        .clk(clk), .we(q_we), .waddr(v_wa), .wdata(res32),
        .raddr(i_reg), .rdata(q_rd)
    );

    cgs_div u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= 5'd1;
            limit_reg <= 16'd1;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                cgs_pkg::CFG_DIMENSION: dim_reg   <= cfg_ch.data[cgs_pkg::DIM_W-1:0];
                cgs_pkg::CFG_ITER_LIM:  limit_reg <= cfg_ch.data[cgs_pkg::ITER_W-1:0];
                default:                dim_reg   <= dim_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            prod_reg <= opa * opb;
            init_reg <= init_val;
        end
        if (acc_step)
        begin
            acc_reg <= acc_new;
            if (elem_last && op_reg == cgs_pkg::OP_RR)
                rr_reg <= res32;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= cgs_pkg::OP_RES;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= 5'd1;
            iter_reg  <= '0;
            fault_reg <= 1'b0;
            alpha_reg <= '0;
            beta_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.mode == cgs_pkg::MODE_START)
                    begin
                        n_reg     <= n_start;
                        fault_reg <= 1'b0;
                        op_reg    <= cgs_pkg::OP_RES;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        iter_reg  <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= S_RD;
                    if (!inner_done)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else if (!elem_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= '0;
                        i_reg <= '0;
                        case (op_reg)
                            cgs_pkg::OP_RES:
                            begin
                                if (limit_reg == '0)
                                    state_reg <= S_ORD;
                                else
                                    op_reg <= cgs_pkg::OP_Q;
                            end
                            cgs_pkg::OP_Q:  op_reg <= cgs_pkg::OP_RR;
                            cgs_pkg::OP_RR: op_reg <= cgs_pkg::OP_PQ;
                            cgs_pkg::OP_PQ: state_reg <= S_DIV;
                            cgs_pkg::OP_X:  op_reg <= cgs_pkg::OP_R;
                            cgs_pkg::OP_R:  op_reg <= cgs_pkg::OP_RN;
                            cgs_pkg::OP_RN: state_reg <= S_DIV;
                            cgs_pkg::OP_P:
                            begin
                                iter_reg <= iter_reg + 1'b1;
                                if (iter_reg + 1'b1 == limit_reg)
                                    state_reg <= S_ORD;
                                else
                                    op_reg <= cgs_pkg::OP_Q;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        fault_reg <= fault_reg | div_rsp.zero;
                        state_reg <= S_RD;
                        if (op_reg == cgs_pkg::OP_PQ)
                        begin
                            alpha_reg <= div_rsp.quot;
                            op_reg    <= cgs_pkg::OP_X;
                        end
                        else
                        begin
                            beta_reg <= div_rsp.quot;
                            op_reg   <= cgs_pkg::OP_P;
                        end
                    end
                end
                S_ORD:
                begin
                    state_reg <= S_OWAIT;
                end
                S_OWAIT:
                begin
                    if (out_ch.ready)
                    begin
                        if (elem_last)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_ORD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign cfg_ch.ready    = 1'b1;
    assign out_ch.valid    = (state_reg == S_OWAIT);
    assign out_ch.index    = i_reg;
    assign out_ch.solution = $signed(x_rd);
    assign out_ch.last     = elem_last;
    assign out_ch.status   = fault_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input taken while results pending");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.last) |-> (32'(out_ch.index) + 32'd1 == 32'(n_reg)))
        else $error("last flag on wrong element");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide step");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == S_DIV))
        else $error("divider started without waiting");

endmodule

`default_nettype wire

### sv/conjugate_gradient_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: a start runs a residual matrix pass, then per iteration one matrix pass,
//   six vector passes and two divides (a zero divisor skips the divide's shifting),
//   on one shared multiply-accumulate walking the stores and a 48-step divider
// throughput: one load per cycle while idle; one solve at a time; results wait for ready
// reset: control and configuration clear (dimension 1, iteration limit 1);
//   store contents are undefined until loaded
// ----------------------------------------------------------------------------
// conjugate_gradient_solver
// fixed-iteration conjugate gradient solver over q16.16 stores
// ----------------------------------------------------------------------------
module conjugate_gradient_solver (
    input  wire logic clk,
    input  wire logic rst_n,
    cgs_in_if.sink    in_ch,
    cgs_out_if.source out_ch,
    cgs_cfg_if.sink   cfg_ch
);

    cgs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

endmodule

`default_nettype wire
